// ===== design/nfci_pkg.sv =====
// Package: shared constants of the NOR flash command interface.
`timescale 1ns / 1ps

package nfci_pkg;

    // Geometry defaults
    localparam int ADDR_BITS_DEF   = 16;
    localparam int SECTOR_BITS_DEF = 12;

    // Field widths
    localparam int BUS_ADDR_W = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;

    // Bus access kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAKER_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_ID  = 1'b1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] MAKER_ID_RST = 8'hBF;
    localparam logic [BYTE_W-1:0] PART_ID_RST  = 8'hB5;

    // Unlock sequence
    localparam logic [BUS_ADDR_W-1:0] UNLOCK_ADDR_A = 16'h5555;
    localparam logic [BUS_ADDR_W-1:0] UNLOCK_ADDR_B = 16'h2AAA;
    localparam logic [BYTE_W-1:0]     UNLOCK_DATA_A = 8'hAA;
    localparam logic [BYTE_W-1:0]     UNLOCK_DATA_B = 8'h55;

    // Command codes
    localparam logic [BYTE_W-1:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [BYTE_W-1:0] CMD_ID_ENTER     = 8'h90;
    localparam logic [BYTE_W-1:0] CMD_ID_EXIT      = 8'hF0;
    localparam logic [BYTE_W-1:0] CMD_ERASE_SETUP  = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_SECTOR_ERASE = 8'h30;

    // Erased byte value
    localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

endpackage

// ===== design/nor_flash_command_interface_top.sv =====
// Top level: NOR flash command interface with byte array, command decoder and ID mode.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid / in_stall, action, addr, data): one bus access per
//   transaction. A write runs the standard unlock / command decoder, a read
//   returns an array byte, or maker_id / part_id while ID mode is active.
// - Output channel (out_valid / out_stall, read_data, in_id_mode): exactly one
//   result transaction per input transaction, in order.
// - Configuration: cfg_we / cfg_index / cfg_data write maker_id (0) or part_id (1).
// - Sequencing: an array read and a program step each add a second state
//   (S_READ, S_PROG), set by the single port byte memory (read, then
//   read-modify-write on the same port); other accesses end in S_IDLE. A
//   sector erase writes 2^SECTOR_BITS bytes (whole array if SECTOR_BITS >=
//   ADDR_BITS), one byte written per cycle.
// - Result: registered in the output queue; an array read is pushed from S_READ.
// - Reset: a clearing pass writes 0xFF into all 2^ADDR_BITS bytes, one per
//   cycle; in_stall stays high throughout the pass. Config writes are
//   taken at any time.
// - Receiver stall: a two-entry output queue holds results; the block keeps
//   accepting while one result waits and stalls its input once both are full.
module nor_flash_command_interface_top #(
    parameter int ADDR_BITS   = nfci_pkg::ADDR_BITS_DEF,
    parameter int SECTOR_BITS = nfci_pkg::SECTOR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [nfci_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nfci_pkg::BYTE_W-1:0]        cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic [nfci_pkg::BUS_ADDR_W-1:0]    addr,
    input  logic [nfci_pkg::BYTE_W-1:0]        data,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [nfci_pkg::BYTE_W-1:0]        read_data,
    output logic                               in_id_mode
);

    localparam int ARRAY_DEPTH = 1 << ADDR_BITS;
    // Bytes touched by one erase: one sector, or the whole array.
    localparam int SWEEP_BITS  = (SECTOR_BITS >= ADDR_BITS) ? ADDR_BITS : SECTOR_BITS;
    localparam logic [ADDR_BITS-1:0] SWEEP_MASK = ADDR_BITS'((64'd1 << SWEEP_BITS) - 64'd1);

    // Control sequencer
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_PROG  = 5'b01000,
        S_ERASE = 5'b10000
    } ctrl_state_t;

    // Command decoder phases
    typedef enum logic [6:0] {
        P_IDLE    = 7'b0000001,
        P_UNLOCK1 = 7'b0000010,
        P_UNLOCK2 = 7'b0000100,
        P_PROGRAM = 7'b0001000,
        P_ERASE0  = 7'b0010000,
        P_ERASE1  = 7'b0100000,
        P_ERASE2  = 7'b1000000
    } cmd_phase_t;

    // Control and payload registers
    ctrl_state_t                    state_reg,      state_next;
    cmd_phase_t                     phase_reg,      phase_next;
    logic                           id_active_reg,  id_active_next;
    logic [ADDR_BITS-1:0]           sweep_reg,      sweep_next;
    logic [ADDR_BITS-1:0]           op_addr_reg,    op_addr_next;
    logic [nfci_pkg::BYTE_W-1:0]    op_data_reg,    op_data_next;
    logic [nfci_pkg::BYTE_W-1:0]    maker_id_reg;
    logic [nfci_pkg::BYTE_W-1:0]    part_id_reg;

    // Output queue: head register plus one skid entry
    logic                           out_valid_reg;
    logic [nfci_pkg::BYTE_W-1:0]    out_rd_reg;
    logic                           out_id_reg;
    logic                           skid_valid_reg;
    logic [nfci_pkg::BYTE_W-1:0]    skid_rd_reg;
    logic                           skid_id_reg;

    // Byte array
    logic [nfci_pkg::BYTE_W-1:0]    mem [ARRAY_DEPTH];
    logic [nfci_pkg::BYTE_W-1:0]    mem_q;
    logic                           mem_we;
    logic [ADDR_BITS-1:0]           mem_addr;
    logic [nfci_pkg::BYTE_W-1:0]    mem_wdata;

    // Datapath signals
    logic                           accept;
    logic                           at_a;
    logic                           at_b;
    logic [ADDR_BITS-1:0]           idx;
    logic                           push;
    logic [nfci_pkg::BYTE_W-1:0]    push_rd;
    logic                           push_id;
    logic                           pop;

    assign in_stall = (state_reg != S_IDLE) || skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign at_a     = (addr == nfci_pkg::UNLOCK_ADDR_A);
    assign at_b     = (addr == nfci_pkg::UNLOCK_ADDR_B);
    // Array index: low ADDR_BITS of the bus address, zero extended if wider.
    assign idx      = ADDR_BITS'(addr);
    assign pop      = out_valid_reg && !out_stall;

    // Sequencer, command decoder and memory port control
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        id_active_next = id_active_reg;
        sweep_next     = sweep_reg;
        op_addr_next   = op_addr_reg;
        op_data_next   = op_data_reg;
        mem_we         = 1'b0;
        mem_addr       = idx;
        mem_wdata      = nfci_pkg::ERASED_BYTE;
        push           = 1'b0;
        push_rd        = '0;
        push_id        = id_active_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Post-reset fill: one byte per cycle across the whole array.
                mem_we     = 1'b1;
                mem_addr   = sweep_reg;
                sweep_next = sweep_reg + ADDR_BITS'(1);
                if (&sweep_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERASE:
            begin
                // op_addr_reg holds the sector base; the low bits step through it.
                mem_we     = 1'b1;
                mem_addr   = op_addr_reg | (sweep_reg & SWEEP_MASK);
                sweep_next = sweep_reg + ADDR_BITS'(1);
                if ((sweep_reg & SWEEP_MASK) == SWEEP_MASK)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                // Array data (mem_q) arrives in the cycle after the read was issued.
                push       = 1'b1;
                push_rd    = mem_q;
                push_id    = id_active_reg;
                state_next = S_IDLE;
            end
            S_PROG:
            begin
                // Write back: programming only clears bits.
                mem_we     = 1'b1;
                mem_addr   = op_addr_reg;
                mem_wdata  = mem_q & op_data_reg;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == nfci_pkg::ACT_READ)
                    begin
                        if (id_active_reg)
                        begin
                            push    = 1'b1;
                            push_rd = addr[0] ? part_id_reg : maker_id_reg;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        phase_next = P_IDLE;
                        case (phase_reg)
                            P_IDLE:
                            begin
                                if (at_a && data == nfci_pkg::UNLOCK_DATA_A)
                                begin
                                    phase_next = P_UNLOCK1;
                                end
                            end
                            P_UNLOCK1:
                            begin
                                if (at_b && data == nfci_pkg::UNLOCK_DATA_B)
                                begin
                                    phase_next = P_UNLOCK2;
                                end
                            end
                            P_UNLOCK2:
                            begin
                                if (at_a)
                                begin
                                    if (data == nfci_pkg::CMD_PROGRAM)
                                    begin
                                        phase_next = P_PROGRAM;
                                    end
                                    else if (data == nfci_pkg::CMD_ERASE_SETUP)
                                    begin
                                        phase_next = P_ERASE0;
                                    end
                                    else if (data == nfci_pkg::CMD_ID_ENTER)
                                    begin
                                        id_active_next = 1'b1;
                                    end
                                    else if (data == nfci_pkg::CMD_ID_EXIT)
                                    begin
                                        id_active_next = 1'b0;
                                    end
                                end
                            end
                            P_PROGRAM:
                            begin
                                // Read now (mem_addr = idx), modify and write next cycle.
                                op_addr_next = idx;
                                op_data_next = data;
                                state_next   = S_PROG;
                            end
                            P_ERASE0:
                            begin
                                if (at_a && data == nfci_pkg::UNLOCK_DATA_A)
                                begin
                                    phase_next = P_ERASE1;
                                end
                            end
                            P_ERASE1:
                            begin
                                if (at_b && data == nfci_pkg::UNLOCK_DATA_B)
                                begin
                                    phase_next = P_ERASE2;
                                end
                            end
                            P_ERASE2:
                            begin
                                if (data == nfci_pkg::CMD_SECTOR_ERASE)
                                begin
                                    op_addr_next = idx & ~SWEEP_MASK;
                                    sweep_next   = '0;
                                    state_next   = S_ERASE;
                                end
                            end
                            default:
                            begin
                                phase_next = P_IDLE;
                            end
                        endcase
                        // Writes report zero and the mode after the access.
                        push    = 1'b1;
                        push_rd = '0;
                        push_id = id_active_next;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Single port byte memory, read-first, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q <= mem[mem_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            phase_reg     <= P_IDLE;
            id_active_reg <= 1'b0;
            sweep_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            id_active_reg <= id_active_next;
            sweep_reg     <= sweep_next;
        end
    end

    // Operation payload
    always_ff @(posedge clk)
    begin
        op_addr_reg <= op_addr_next;
        op_data_reg <= op_data_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maker_id_reg <= nfci_pkg::MAKER_ID_RST;
            part_id_reg  <= nfci_pkg::PART_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nfci_pkg::CFG_MAKER_ID: maker_id_reg <= cfg_data;
                nfci_pkg::CFG_PART_ID:  part_id_reg  <= cfg_data;
                default:                maker_id_reg <= maker_id_reg;
            endcase
        end
    end

    // Output queue valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            // Head frees up: refill from skid first, then from a new result.
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output queue payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_rd_reg  <= skid_rd_reg;
                out_id_reg  <= skid_id_reg;
                skid_rd_reg <= push_rd;
                skid_id_reg <= push_id;
            end
            else
            begin
                out_rd_reg <= push_rd;
                out_id_reg <= push_id;
            end
        end
        else if (push)
        begin
            skid_rd_reg <= push_rd;
            skid_id_reg <= push_id;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_rd_reg;
    assign in_id_mode = out_id_reg;

endmodule
